// ===== src/utar_pkg.sv =====
// ----------------------------------------------------------------------------
// utar_pkg: shared types and constants of the ustar archive deframer
// Result record, result kinds, end status codes and header field offsets.
// ----------------------------------------------------------------------------
package utar_pkg;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_START   = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    localparam logic [1:0] STATUS_ZERO_BLOCK = 2'd0;
    localparam logic [1:0] STATUS_CLEAN      = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;

    localparam logic [8:0] NAME_LAST  = 9'd98;
    localparam logic [8:0] SIZE_FIRST = 9'd124;
    localparam logic [8:0] SIZE_LAST  = 9'd135;
    localparam logic [8:0] TYPE_AT    = 9'd156;
    localparam logic [8:0] BLOCK_LAST = 9'd511;

    localparam int TDATA_W = 88;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  out_byte;
        logic [6:0]  name_offset;
        logic [35:0] file_size;
        logic [15:0] file_number;
        logic        extract_flag;
        logic        last_payload;
        logic [1:0]  end_status;
        logic [15:0] files_extracted;
    } result_t;

    // Up to two results follow from one input byte; the second is always the
    // archive end caused by the final byte of the stream.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    first_valid;
        logic    second_valid;
    } step_out_t;

endpackage

// ===== src/utar_parser.sv =====
// ----------------------------------------------------------------------------
// utar_parser: block walker of the ustar archive deframer
// Holds the archive state and turns one accepted byte into its results.
// ----------------------------------------------------------------------------
module utar_parser
    import utar_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output step_out_t  step_out
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PADDING = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  offset_reg, offset_next;
    logic        zero_reg, zero_next;
    logic [35:0] acc_reg, acc_next;
    logic        stop_reg, stop_next;
    logic [7:0]  type_reg, type_next;
    logic [35:0] remain_reg, remain_next;
    logic [8:0]  pad_reg, pad_next;
    logic [15:0] entries_reg, entries_next;
    logic [15:0] extracted_reg, extracted_next;

    result_t prim;
    result_t fin;
    logic    prim_v;
    logic    fin_v;
    logic    ended;
    logic    count_it;
    logic    count_ext;
    logic    ext;

    function automatic logic is_regular(input logic [7:0] t);
        return (t == 8'h30) || (t == 8'h00);
    endfunction

    always_comb begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        zero_next      = zero_reg;
        acc_next       = acc_reg;
        stop_next      = stop_reg;
        type_next      = type_reg;
        remain_next    = remain_reg;
        pad_next       = pad_reg;
        entries_next   = entries_reg;
        extracted_next = extracted_reg;
        prim           = '0;
        prim_v         = 1'b0;
        ended          = 1'b0;
        count_it       = 1'b0;
        count_ext      = 1'b0;
        ext            = 1'b0;
        fin            = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (offset_reg == 9'd0) begin
                    zero_next = 1'b1;
                    acc_next  = '0;
                    stop_next = 1'b0;
                    type_next = '0;
                end
                if (in_byte != 8'd0) begin
                    zero_next = 1'b0;
                end
                if (offset_reg <= NAME_LAST) begin
                    prim_v               = 1'b1;
                    prim.result_kind     = KIND_NAME;
                    prim.out_byte        = in_byte;
                    prim.name_offset     = offset_reg[6:0];
                    prim.file_number     = entries_reg;
                    prim.files_extracted = extracted_reg;
                end
                if (offset_reg >= SIZE_FIRST && offset_reg <= SIZE_LAST && !stop_next) begin
                    if (in_byte >= 8'h30 && in_byte <= 8'h37) begin
                        acc_next = {acc_next[32:0], in_byte[2:0]};
                    end else if (in_byte == 8'h20 || in_byte == 8'h00) begin
                        stop_next = 1'b1;
                    end
                end
                if (offset_reg == TYPE_AT) begin
                    type_next = in_byte;
                end
                if (offset_reg == BLOCK_LAST) begin
                    offset_next = '0;
                    if (zero_next) begin
                        prim_v               = 1'b1;
                        prim.result_kind     = KIND_END;
                        prim.end_status      = STATUS_ZERO_BLOCK;
                        prim.file_number     = entries_reg;
                        prim.files_extracted = extracted_reg;
                        phase_next           = PH_DONE;
                        ended                = 1'b1;
                    end else begin
                        ext                  = is_regular(type_next);
                        prim_v               = 1'b1;
                        prim.result_kind     = KIND_START;
                        prim.file_size       = acc_next;
                        prim.extract_flag    = ext;
                        prim.file_number     = entries_reg;
                        prim.files_extracted = extracted_reg;
                        remain_next          = acc_next;
                        pad_next             = 9'd0 - acc_next[8:0];
                        if (acc_next == 36'd0) begin
                            count_it  = 1'b1;
                            count_ext = ext;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end else begin
                    offset_next = offset_reg + 9'd1;
                end
            end
            PH_PAYLOAD: begin
                ext = is_regular(type_reg);
                if (ext) begin
                    prim_v               = 1'b1;
                    prim.result_kind     = KIND_PAYLOAD;
                    prim.out_byte        = in_byte;
                    prim.file_size       = acc_reg;
                    prim.extract_flag    = 1'b1;
                    prim.last_payload    = (remain_reg == 36'd1);
                    prim.file_number     = entries_reg;
                    prim.files_extracted = extracted_reg;
                end
                remain_next = remain_reg - 36'd1;
                if (remain_next == 36'd0) begin
                    count_it   = 1'b1;
                    count_ext  = ext;
                    phase_next = (pad_reg != 9'd0) ? PH_PADDING : PH_HEADER;
                end
            end
            PH_PADDING: begin
                pad_next = pad_reg - 9'd1;
                if (pad_next == 9'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_DONE: begin
            end
        endcase

        if (count_it) begin
            if (entries_reg != 16'hFFFF) begin
                entries_next = entries_reg + 16'd1;
            end
            if (count_ext && extracted_reg != 16'hFFFF) begin
                extracted_next = extracted_reg + 16'd1;
            end
        end

        fin.result_kind     = KIND_END;
        fin.file_number     = entries_next;
        fin.files_extracted = extracted_next;
        if (phase_next == PH_PAYLOAD && remain_next != 36'd0) begin
            fin.end_status = STATUS_TRUNCATED;
            fin.file_size  = acc_next;
        end else begin
            fin.end_status = STATUS_CLEAN;
        end
        fin_v = in_last && (phase_reg != PH_DONE) && !ended;

        // The final byte of a stream puts everything back to the reset state.
        if (in_last) begin
            phase_next     = PH_HEADER;
            offset_next    = '0;
            zero_next      = 1'b1;
            acc_next       = '0;
            stop_next      = 1'b0;
            type_next      = '0;
            remain_next    = '0;
            pad_next       = '0;
            entries_next   = '0;
            extracted_next = '0;
        end
    end

    always_comb begin
        step_out.first        = prim_v ? prim : fin;
        step_out.second       = fin;
        step_out.first_valid  = prim_v || fin_v;
        step_out.second_valid = prim_v && fin_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            offset_reg    <= '0;
            zero_reg      <= 1'b1;
            acc_reg       <= '0;
            stop_reg      <= 1'b0;
            type_reg      <= '0;
            remain_reg    <= '0;
            pad_reg       <= '0;
            entries_reg   <= '0;
            extracted_reg <= '0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            zero_reg      <= zero_next;
            acc_reg       <= acc_next;
            stop_reg      <= stop_next;
            type_reg      <= type_next;
            remain_reg    <= remain_next;
            pad_reg       <= pad_next;
            entries_reg   <= entries_next;
            extracted_reg <= extracted_next;
        end
    end

endmodule

// ===== src/ustar_archive_deframer.sv =====
// ----------------------------------------------------------------------------
// ustar_archive_deframer: ustar archive byte stream to name/file/payload records
// Walks 512-byte header, payload and padding blocks and reports each entry.
// ----------------------------------------------------------------------------
//   channel | direction | tdata                  | tuser       | tlast
//   s_      | in        | data_byte              | -           | archive_last
//   m_      | out       | record fields (88 bit) | result_kind | last_payload
//
// One byte is accepted per clock unless m_ stalls or a second result waits.
// Its results are computed in the same cycle from the parser state and land
// in a two-entry output register. Only the final byte of a stream can yield
// two results; input then pauses while the second one drains.
// Reset is synchronous and clears the parser state and empties the output register.
// A stall on m_ backs up to s_tready within the same cycle.
module ustar_archive_deframer
    import utar_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] out_byte, [14:8] name_offset, [50:15] file_size,
    // [66:51] file_number, [67] extract_flag, [69:68] end_status,
    // [85:70] files_extracted, [87:86] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // [1:0] result_kind
    output logic               m_tlast
);

    step_out_t step_out;
    result_t   out0_reg;
    result_t   out1_reg;
    logic      out0_valid_reg;
    logic      out1_valid_reg;
    logic      in_accept;
    logic      out_take;

    assign s_tready  = !out1_valid_reg && (!out0_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out0_valid_reg && m_tready;

    utar_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .step_out  (step_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out0_valid_reg <= 1'b0;
            out1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            // Accepting implies the output register is empty or drains now.
            out0_reg       <= step_out.first;
            out1_reg       <= step_out.second;
            out0_valid_reg <= step_out.first_valid;
            out1_valid_reg <= step_out.second_valid;
        end else if (out_take) begin
            out0_reg       <= out1_reg;
            out0_valid_reg <= out1_valid_reg;
            out1_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out0_valid_reg;
    assign m_tuser  = out0_reg.result_kind;
    assign m_tlast  = out0_reg.last_payload;
    assign m_tdata  = {2'b00,
                       out0_reg.files_extracted,
                       out0_reg.end_status,
                       out0_reg.extract_flag,
                       out0_reg.file_number,
                       out0_reg.file_size,
                       out0_reg.name_offset,
                       out0_reg.out_byte};

endmodule

// ===== src/utar_checker.sv =====
// ----------------------------------------------------------------------------
// utar_checker: port-level checks of the ustar archive deframer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module utar_checker
    import utar_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser,
    input logic               m_tlast
);

    // A stalled transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Name bytes only come from the first 99 header positions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NAME |-> m_tdata[14:8] <= 7'd98)
        else $error("name offset out of range");

    // The last payload marker only comes on an extracted payload byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD && m_tdata[67])
        else $error("last payload marker on a non-payload result");

    // End status is carried by archive end records alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_END |-> m_tdata[69:68] == 2'd0)
        else $error("end status set outside an archive end");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind ustar_archive_deframer utar_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
